[hdl/x86_64_instruction_length_decoder_macros.svh]
// Assertion macros shared by the length decoder RTL.
`ifndef X86_64_INSTRUCTION_LENGTH_DECODER_MACROS_SVH
`define X86_64_INSTRUCTION_LENGTH_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XILD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define XILD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/xild_pkg.sv]
// Types, codes and opcode tables for the x86-64 length decoder.
package xild_pkg;

   localparam int unsigned LEN_W  = 6;
   localparam int unsigned DISP_W = 5;
   localparam int unsigned CNT4_W = 4;

   typedef enum logic [4:0] {
      PH_PREFIX = 5'b00001,
      PH_OPCODE = 5'b00010,
      PH_MODRM  = 5'b00100,
      PH_SIB    = 5'b01000,
      PH_TAIL   = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_DECODED     = 2'd0,
      ST_UNSUPPORTED = 2'd1,
      ST_TRUNCATED   = 2'd2
   } status_type;

   localparam logic [7:0] OP_ADDR_SIZE = 8'h67;
   localparam logic [7:0] OP_OPND_SIZE = 8'h66;
   localparam logic [7:0] OP_POP_RM    = 8'h8F;
   localparam logic [7:0] OP_MOV_RM8   = 8'hC6;
   localparam logic [7:0] OP_MOV_RM    = 8'hC7;
   localparam logic [7:0] OP_GRP4      = 8'hFE;
   localparam logic [7:0] OP_GRP5      = 8'hFF;

   // Legacy prefix, operand-size and address-size included.
   function automatic logic is_prefix(input logic [7:0] b);
      return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
             b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 || b == OP_OPND_SIZE ||
             b == OP_ADDR_SIZE;
   endfunction

   // Escapes, VEX/EVEX, relative branches and INT imm8.
   function automatic logic is_rejected(input logic [7:0] b);
      return b == 8'h0F || b == 8'h62 || b == 8'hC4 || b == 8'hC5 || b == 8'hCD ||
             b == 8'hE8 || b == 8'hE9 || b == 8'hEB ||
             (b >= 8'h70 && b <= 8'h7F) || (b >= 8'hE0 && b <= 8'hE3);
   endfunction

   function automatic logic has_modrm(input logic [7:0] op);
      logic r;
      priority if (op <= 8'h3B) r = (op[2:0] <= 3'd3);
      else if (op == 8'h62 || op == 8'h63 || op == 8'h69 || op == 8'h6B) r = 1'b1;
      else if (op >= 8'h80 && op <= 8'h8F) r = 1'b1;
      else if (op == 8'hC0 || op == 8'hC1 || op == OP_MOV_RM8 || op == OP_MOV_RM) r = 1'b1;
      else if (op >= 8'hD0 && op <= 8'hD3) r = 1'b1;
      else r = (op == 8'hF6 || op == 8'hF7 || op == OP_GRP4 || op == OP_GRP5);
      return r;
   endfunction

   function automatic logic plain_ok(input logic [7:0] op);
      return (op >= 8'h50 && op <= 8'h5F) || (op >= 8'hB0 && op <= 8'hBF) ||
             op == 8'h68 || op == 8'h6A || op == 8'h90 || op == 8'h98 || op == 8'h99 ||
             op == 8'h9C || op == 8'h9D || (op >= 8'hF8 && op <= 8'hFD);
   endfunction

   // Immediate bytes for an opcode, given /digit, REX.W and the 66 prefix.
   function automatic logic [CNT4_W-1:0] imm_bytes(input logic [7:0] op,
                                                   input logic [2:0] digit,
                                                   input logic       wide,
                                                   input logic       osz);
      logic [CNT4_W-1:0] full;
      logic [CNT4_W-1:0] r;
      full = (osz && !wide) ? 4'd2 : 4'd4;
      priority if (op >= 8'hB0 && op <= 8'hB7) r = 4'd1;
      else if (op >= 8'hB8 && op <= 8'hBF) r = wide ? 4'd8 : (osz ? 4'd2 : 4'd4);
      else if (op == 8'h68) r = osz ? 4'd2 : 4'd4;
      else if (op == 8'h69 || op == 8'hA9 || op == OP_MOV_RM || op == 8'h81) r = full;
      else if (op == 8'h6B || op == 8'h6A || op == 8'h80 || op == 8'h82 || op == 8'h83 ||
               op == 8'hC0 || op == 8'hC1 || op == 8'hCD || op == 8'hA8 ||
               op == OP_MOV_RM8) r = 4'd1;
      else if (op == 8'hF6) r = (digit == 3'd0) ? 4'd1 : 4'd0;
      else if (op == 8'hF7) r = (digit == 3'd0) ? full : 4'd0;
      else r = 4'd0;
      return r;
   endfunction

endpackage

[hdl/xild_if.sv]
// Valid/ready channel interfaces for code bytes and length results.
interface xild_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_available;

   modport source (output valid, code_byte, last_available, input ready);
   modport sink   (input valid, code_byte, last_available, output ready);
endinterface

interface xild_rsp_if;
   logic                             valid;
   logic                             ready;
   xild_pkg::status_type             status;
   logic [xild_pkg::LEN_W-1:0]       instr_length;
   logic                             rip_relative;
   logic [xild_pkg::DISP_W-1:0]      disp_offset;

   modport source (output valid, status, instr_length, rip_relative, disp_offset,
                   input ready);
   modport sink   (input valid, status, instr_length, rip_relative, disp_offset,
                   output ready);
endinterface

[hdl/x86_64_instruction_length_decoder.sv]
// x86-64 instruction length decoder: one code byte in per cycle unless rsp_ch stalls,
// one result per instruction. Feed code bytes one per transfer on req_ch; last_available
// marks the final byte of a buffer. Each byte lands in an input register, from which a
// small phase machine (prefix, REX, opcode, ModRM, SIB, displacement/immediate countdown)
// folds it into the per-instruction state and, when the instruction completes, is rejected,
// or runs out of bytes, loads one result into the output register for rsp_ch. The block
// sustains one byte per cycle unless rsp_ch stalls; a result is offered once the byte that
// ends it has passed the input register and the decode stage. The output register is the
// only result buffer, so a stalled rsp_ch holds the decode stage, while the input register
// still takes one more byte. After every result the decode state clears and the next byte
// starts a new instruction. Status 0 carries the length and RIP-relative information;
// status 1 (unsupported: 0F escapes, VEX/EVEX, 67, relative branches, INT imm8, unknown
// opcodes, bad /digit) and status 2 (truncated, or MAX_INSTR_BYTES reached) report length 0.
module x86_64_instruction_length_decoder #(
   parameter int unsigned MAX_INSTR_BYTES = 32
) (
   input logic      clock,
   input logic      reset,
   xild_req_if.sink   req_ch,
   xild_rsp_if.source rsp_ch
);
   import xild_pkg::*;

`include "x86_64_instruction_length_decoder_macros.svh"

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   // decode state
   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              osz_ff, osz_in;
   logic              wide_ff, wide_in;
   logic [7:0]        opcode_ff, opcode_in;
   logic [2:0]        digit_ff, digit_in;
   logic              rip_ff, rip_in;
   logic [DISP_W-1:0] dpos_ff, dpos_in;
   logic [CNT4_W-1:0] skip_ff, skip_in;
   logic [CNT4_W-1:0] imm_ff, imm_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic              out_rip_ff, out_rip_in;
   logic [DISP_W-1:0] out_disp_ff, out_disp_in;

   logic advance;    // decode stage may move: output free or being drained
   logic step;       // a byte is decoded this cycle
   logic produce;    // that byte ends the instruction one way or another
   logic bad, done, as_opcode;
   logic [LEN_W-1:0] cnt;
   logic [1:0] mode;
   logic [2:0] rm;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign step    = in_valid_ff && advance;

   // Take a byte whenever the input register is empty or drains this cycle.
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;

   assign mode = in_byte_ff[7:6];
   assign rm   = in_byte_ff[2:0];
   assign cnt  = count_ff + LEN_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      osz_in    = osz_ff;
      wide_in   = wide_ff;
      opcode_in = opcode_ff;
      digit_in  = digit_ff;
      rip_in    = rip_ff;
      dpos_in   = dpos_ff;
      skip_in   = skip_ff;
      imm_in    = imm_ff;
      bad       = 1'b0;
      done      = 1'b0;
      as_opcode = 1'b0;

      unique case (phase_ff)
         PH_OPCODE: begin
            as_opcode = 1'b1;
         end
         PH_MODRM: begin
            digit_in = in_byte_ff[5:3];
            if ((opcode_ff == OP_POP_RM && digit_in != 3'd0) ||
                ((opcode_ff == OP_MOV_RM8 || opcode_ff == OP_MOV_RM) && digit_in != 3'd0) ||
                (opcode_ff == OP_GRP4 && digit_in > 3'd1) ||
                (opcode_ff == OP_GRP5 && digit_in >= 3'd2 && digit_in <= 3'd5)) begin
               bad = 1'b1;
            end else begin
               imm_in  = imm_bytes(opcode_ff, digit_in, wide_ff, osz_ff);
               skip_in = (mode == 2'd1) ? 4'd1 : ((mode == 2'd2) ? 4'd4 : 4'd0);
               if (mode != 2'd3 && rm == 3'd4) begin
                  phase_in = PH_SIB;
               end else begin
                  // mod 00 with r/m 101: disp32 relative to RIP
                  if (mode == 2'd0 && rm == 3'd5) begin
                     rip_in  = 1'b1;
                     dpos_in = cnt[DISP_W-1:0];
                     skip_in = 4'd4;
                  end
                  done = (skip_in == '0 && imm_in == '0);
                  if (!done) phase_in = PH_TAIL;
               end
            end
         end
         PH_SIB: begin
            // no displacement pending means mod was 00: base 101 adds disp32
            if (skip_ff == '0 && rm == 3'd5) skip_in = 4'd4;
            done = (skip_in == '0 && imm_ff == '0);
            if (!done) phase_in = PH_TAIL;
         end
         PH_TAIL: begin
            if (skip_ff != '0) skip_in = skip_ff - 4'd1;
            else if (imm_ff != '0) imm_in = imm_ff - 4'd1;
            done = (skip_in == '0 && imm_in == '0);
         end
         default: begin
            if (is_prefix(in_byte_ff)) begin
               if (in_byte_ff == OP_ADDR_SIZE) bad = 1'b1;
               else if (in_byte_ff == OP_OPND_SIZE) osz_in = 1'b1;
            end else if (in_byte_ff[7:4] == 4'h4) begin
               // REX: keep W, next byte is the opcode
               wide_in  = in_byte_ff[3];
               phase_in = PH_OPCODE;
            end else begin
               as_opcode = 1'b1;
            end
         end
      endcase

      if (as_opcode) begin
         if (is_rejected(in_byte_ff)) begin
            bad = 1'b1;
         end else if (has_modrm(in_byte_ff)) begin
            opcode_in = in_byte_ff;
            phase_in  = PH_MODRM;
         end else begin
            opcode_in = in_byte_ff;
            imm_in    = imm_bytes(in_byte_ff, 3'd0, wide_in, osz_in);
            if (imm_in == '0 && !plain_ok(in_byte_ff)) begin
               bad = 1'b1;
            end else begin
               skip_in = '0;
               done    = (imm_in == '0);
               if (!done) phase_in = PH_TAIL;
            end
         end
      end

      // Rejection wins over completion, completion over truncation.
      out_len_in  = '0;
      out_rip_in  = 1'b0;
      out_disp_in = '0;
      priority if (bad) begin
         out_status_in = ST_UNSUPPORTED;
      end else if (done) begin
         out_status_in = ST_DECODED;
         out_len_in    = cnt;
         out_rip_in    = rip_in;
         out_disp_in   = rip_in ? dpos_in : '0;
      end else begin
         out_status_in = ST_TRUNCATED;
      end
      produce = bad || done || in_last_ff || (cnt >= LEN_W'(MAX_INSTR_BYTES));

      count_in = cnt;
      // Clear state after any result.
      if (produce) begin
         phase_in  = PH_PREFIX;
         count_in  = '0;
         osz_in    = 1'b0;
         wide_in   = 1'b0;
         opcode_in = '0;
         digit_in  = '0;
         rip_in    = 1'b0;
         dpos_in   = '0;
         skip_in   = '0;
         imm_in    = '0;
      end
   end

   // Hold the result until it transfers; load a new one only when the stage advances.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = step && produce;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_PREFIX;
         count_ff     <= '0;
         osz_ff       <= 1'b0;
         wide_ff      <= 1'b0;
         opcode_ff    <= '0;
         digit_ff     <= '0;
         rip_ff       <= 1'b0;
         dpos_ff      <= '0;
         skip_ff      <= '0;
         imm_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            osz_ff    <= osz_in;
            wide_ff   <= wide_in;
            opcode_ff <= opcode_in;
            digit_ff  <= digit_in;
            rip_ff    <= rip_in;
            dpos_ff   <= dpos_in;
            skip_ff   <= skip_in;
            imm_ff    <= imm_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_byte_ff <= req_ch.code_byte;
         in_last_ff <= req_ch.last_available;
      end
      if (step && produce) begin
         out_status_ff <= out_status_in;
         out_len_ff    <= out_len_in;
         out_rip_ff    <= out_rip_in;
         out_disp_ff   <= out_disp_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.instr_length = out_len_ff;
   assign rsp_ch.rip_relative = out_rip_ff;
   assign rsp_ch.disp_offset  = out_disp_ff;

   `XILD_ASSERT_NOW(a_err_len_zero, clock, reset, out_valid_ff && out_status_ff != ST_DECODED, out_len_ff == '0 && !out_rip_ff && out_disp_ff == '0, "error result carries length or RIP info")
   `XILD_ASSERT_NOW(a_rip_offset, clock, reset, out_valid_ff && out_rip_ff, out_status_ff == ST_DECODED && out_disp_ff != '0 && LEN_W'(out_disp_ff) < out_len_ff, "RIP-relative offset outside instruction")
   `XILD_ASSERT_NEXT(a_clear_after_result, clock, reset, step && produce, phase_ff == PH_PREFIX && count_ff == '0 && skip_ff == '0 && imm_ff == '0, "decode state not cleared after result")
   `XILD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff < LEN_W'(MAX_INSTR_BYTES), "byte count reached the instruction limit")

endmodule
